// ===== sv/max_heap_priority_queue_assert.svh =====
// assertion macros used by the heap queue datapath
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int unsigned CAPACITY  = 128;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned IDX_W     = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CHILD_W   = IDX_W + 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OUT_W     = ((2 * DATA_W + COUNT_W + STATUS_W + 7) / 8) * 8;

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [ADDR_W-1:0]           addr_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UP_RD,
    OP_UP_CMP,
    OP_RM_RD,
    OP_RM_LD,
    OP_DN_RD,
    OP_DN_CMP,
    OP_FIN_RD,
    OP_FIN_LD
  } op_e;

  typedef struct packed {
    logic refuse;
    logic in_remove;
    logic at_root;
    logic up_swap;
    logic last_one;
    logic no_child;
    logic dn_swap;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/mhpq_ctrl.sv =====
module mhpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  mhpq_pkg::dp_status_t st_i,
  output mhpq_pkg::op_e       op_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_RM_RD  = 4'd3;
  localparam logic [3:0] S_RM_LD  = 4'd4;
  localparam logic [3:0] S_DN_RD  = 4'd5;
  localparam logic [3:0] S_DN_CMP = 4'd6;
  localparam logic [3:0] S_FIN_RD = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = mhpq_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          op_o = mhpq_pkg::OP_ACCEPT;
          if (st_i.refuse) state_d = S_FIN_RD;
          else if (st_i.in_remove) state_d = S_RM_RD;
          else state_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        op_o    = mhpq_pkg::OP_UP_RD;
        state_d = st_i.at_root ? S_FIN_RD : S_UP_CMP;
      end
      S_UP_CMP: begin
        op_o    = mhpq_pkg::OP_UP_CMP;
        state_d = st_i.up_swap ? S_UP_RD : S_FIN_RD;
      end
      S_RM_RD: begin
        op_o    = mhpq_pkg::OP_RM_RD;
        state_d = S_RM_LD;
      end
      S_RM_LD: begin
        op_o    = mhpq_pkg::OP_RM_LD;
        state_d = st_i.last_one ? S_FIN_RD : S_DN_RD;
      end
      S_DN_RD: begin
        op_o    = mhpq_pkg::OP_DN_RD;
        state_d = st_i.no_child ? S_FIN_RD : S_DN_CMP;
      end
      S_DN_CMP: begin
        op_o    = mhpq_pkg::OP_DN_CMP;
        state_d = st_i.dn_swap ? S_DN_RD : S_FIN_RD;
      end
      S_FIN_RD: begin
        op_o    = mhpq_pkg::OP_FIN_RD;
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (st_i.out_free) begin
          op_o    = mhpq_pkg::OP_FIN_LD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/mhpq_dp.sv =====
`include "max_heap_priority_queue_assert.svh"

module mhpq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mhpq_pkg::op_e                 op_i,
  output mhpq_pkg::dp_status_t          st_o,
  input  logic [0:0]                    s_tuser_i,
  input  logic [31:0]                   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [mhpq_pkg::OUT_W-1:0]    m_tdata_o
);

  // heap held one-based: entry i lives at address i-1
  mhpq_pkg::key_t mem_q [mhpq_pkg::CAPACITY];

  mhpq_pkg::idx_t   count_q, hole_q;
  mhpq_pkg::key_t   val_q, removed_q, rd0_q, rd1_q;
  mhpq_pkg::status_e status_q;

  logic                               m_tvalid_q;
  logic [mhpq_pkg::OUT_W-1:0]         m_tdata_q;

  mhpq_pkg::addr_t raddr0, raddr1, waddr;
  mhpq_pkg::key_t  wdata, cval, top_val, in_key;
  logic            we;

  mhpq_pkg::idx_t                   parent, cidx;
  logic [mhpq_pkg::CHILD_W-1:0]     child_l, child_r;
  logic                             full, empty, r_ok, pick_r;
  logic                             up_swap, dn_swap, no_child, at_root;

  assign in_key   = mhpq_pkg::key_t'(signed'(s_tdata_i));
  assign full     = (count_q == mhpq_pkg::IDX_W'(mhpq_pkg::CAPACITY));
  assign empty    = (count_q == '0);
  assign parent   = hole_q >> 1;
  assign at_root  = (hole_q == mhpq_pkg::IDX_W'(1));
  assign child_l  = {hole_q, 1'b0};
  assign child_r  = child_l + mhpq_pkg::CHILD_W'(1);
  assign no_child = child_l > mhpq_pkg::CHILD_W'(count_q);
  assign r_ok     = child_r <= mhpq_pkg::CHILD_W'(count_q);
  assign pick_r   = r_ok && (rd0_q < rd1_q);
  assign cval     = pick_r ? rd1_q : rd0_q;
  assign cidx     = pick_r ? mhpq_pkg::IDX_W'(child_r) : mhpq_pkg::IDX_W'(child_l);
  assign up_swap  = rd0_q < val_q;
  assign dn_swap  = val_q < cval;
  assign top_val  = empty ? '0 : rd0_q;

  always_comb begin
    st_o.refuse    = s_tuser_i[0] ? empty : full;
    st_o.in_remove = s_tuser_i[0];
    st_o.at_root   = at_root;
    st_o.up_swap   = up_swap;
    st_o.last_one  = (count_q == mhpq_pkg::IDX_W'(1));
    st_o.no_child  = no_child;
    st_o.dn_swap   = dn_swap;
    st_o.out_free  = !m_tvalid_q || m_tready_i;
  end

  // memory port control
  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    we     = 1'b0;
    waddr  = mhpq_pkg::ADDR_W'(hole_q - mhpq_pkg::IDX_W'(1));
    wdata  = val_q;
    unique case (op_i)
      mhpq_pkg::OP_UP_RD: begin
        raddr0 = mhpq_pkg::ADDR_W'(parent - mhpq_pkg::IDX_W'(1));
        we     = at_root;
      end
      mhpq_pkg::OP_UP_CMP: begin
        we    = 1'b1;
        wdata = up_swap ? rd0_q : val_q;
      end
      mhpq_pkg::OP_RM_RD: begin
        raddr1 = mhpq_pkg::ADDR_W'(count_q - mhpq_pkg::IDX_W'(1));
      end
      mhpq_pkg::OP_DN_RD: begin
        raddr0 = mhpq_pkg::ADDR_W'(child_l - mhpq_pkg::CHILD_W'(1));
        raddr1 = mhpq_pkg::ADDR_W'(child_l);
        we     = no_child;
      end
      mhpq_pkg::OP_DN_CMP: begin
        we    = 1'b1;
        wdata = dn_swap ? cval : val_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd0_q <= mem_q[raddr0];
    rd1_q <= mem_q[raddr1];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      mhpq_pkg::OP_ACCEPT: begin
        removed_q <= '0;
        status_q  <= s_tuser_i[0] ? (empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_DONE)
                                  : (full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_DONE);
        hole_q <= count_q + mhpq_pkg::IDX_W'(1);
        val_q  <= in_key;
      end
      mhpq_pkg::OP_UP_CMP: begin
        if (up_swap) hole_q <= parent;
      end
      mhpq_pkg::OP_RM_LD: begin
        removed_q <= rd0_q;
        val_q     <= rd1_q;
        hole_q    <= mhpq_pkg::IDX_W'(1);
      end
      mhpq_pkg::OP_DN_CMP: begin
        if (dn_swap) hole_q <= cidx;
      end
      mhpq_pkg::OP_FIN_LD: begin
        m_tdata_q <= mhpq_pkg::OUT_W'({status_q, mhpq_pkg::COUNT_W'(count_q),
                                       mhpq_pkg::DATA_W'(top_val),
                                       mhpq_pkg::DATA_W'(removed_q)});
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (op_i == mhpq_pkg::OP_ACCEPT && !s_tuser_i[0] && !full) begin
        count_q <= count_q + mhpq_pkg::IDX_W'(1);
      end else if (op_i == mhpq_pkg::OP_RM_LD) begin
        count_q <= count_q - mhpq_pkg::IDX_W'(1);
      end
      if (op_i == mhpq_pkg::OP_FIN_LD) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= mhpq_pkg::IDX_W'(mhpq_pkg::CAPACITY), "count above capacity")
  `MHPQ_ASSERT_NOW(a_hole_range, op_i == mhpq_pkg::OP_UP_CMP || op_i == mhpq_pkg::OP_DN_CMP, hole_q != '0 && hole_q <= count_q, "sift position outside heap")
  `MHPQ_ASSERT_NOW(a_no_load_busy, m_tvalid_q && !m_tready_i, op_i != mhpq_pkg::OP_FIN_LD, "result loaded over a waiting beat")
  `MHPQ_ASSERT_NEXT(a_load_valid, op_i == mhpq_pkg::OP_FIN_LD, m_tvalid_q, "loaded result not presented")

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// binary max-heap priority queue, one result beat per input beat, one item in flight
// insert climbs from the new leaf; removal takes the root, moves the last entry there and sinks it
// refused items go straight to the result; every item ends with a root read and a result load
// each level costs a registered memory read then a compare and write-back; the result load
// waits until the output register is free
// reset clears the entry count and output valid; heap memory is not cleared
module max_heap_priority_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [0:0]                 s_tuser_i,  // [0] mode: 0 insert, 1 remove max
  input  logic [31:0]                s_tdata_i,  // [31:0] value
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  // [31:0] removed_value, [63:32] top_value, [71:64] entry_count, [73:72] status
  output logic [mhpq_pkg::OUT_W-1:0] m_tdata_o
);

  mhpq_pkg::op_e        op;
  mhpq_pkg::dp_status_t st;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .st_i       (st),
    .op_o       (op)
  );

  mhpq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .st_o       (st),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   TAIL_CYCLES = 40;

  typedef struct packed {
    logic        mode;
    logic [31:0] value;
  } heap_op_t;

  typedef struct packed {
    logic [31:0]       removed;
    logic [31:0]       top;
    logic [7:0]        count;
    mhpq_pkg::status_e status;
  } heap_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid_i = 1'b0;
  logic                       s_tready_o;
  logic [0:0]                 s_tuser_i = '0;
  logic [31:0]                s_tdata_i = '0;
  logic                       m_tvalid_o;
  logic                       m_tready_i = 1'b0;
  logic [mhpq_pkg::OUT_W-1:0] m_tdata_o;

  max_heap_priority_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  heap_op_t     pending_ops[$];
  heap_result_t expected_results[$];

  // shadow heap, one-based like the block
  mhpq_pkg::key_t heap_keys [1:mhpq_pkg::CAPACITY];
  int             heap_count;

  int mismatch_count;
  int result_count;
  int insert_count;
  int remove_count;
  int full_refusals;
  int empty_refusals;
  int peak_count;
  int cycle_count;
  int send_gap;
  int send_burst;
  int recv_stall;
  int recv_burst;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic heap_result_t heap_apply(logic mode, logic [31:0] value);
    heap_result_t   r;
    int             idx;
    int             child;
    mhpq_pkg::key_t tmp;
    r.removed = '0;
    r.status  = mhpq_pkg::ST_DONE;
    if (mode == MODE_INSERT) begin
      if (heap_count >= mhpq_pkg::CAPACITY) begin
        r.status = mhpq_pkg::ST_FULL;
        full_refusals++;
      end else begin
        heap_count++;
        idx = heap_count;
        heap_keys[idx] = mhpq_pkg::key_t'(value);
        // climb while the parent is strictly smaller
        while (idx > 1 && heap_keys[idx / 2] < heap_keys[idx]) begin
          tmp = heap_keys[idx / 2];
          heap_keys[idx / 2] = heap_keys[idx];
          heap_keys[idx] = tmp;
          idx = idx / 2;
        end
        insert_count++;
      end
    end else begin
      if (heap_count == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
        empty_refusals++;
      end else begin
        r.removed = heap_keys[1];
        heap_keys[1] = heap_keys[heap_count];
        heap_count--;
        idx = 1;
        // sink toward the larger child, inclusive of the last entry
        while (2 * idx <= heap_count) begin
          child = 2 * idx;
          if (child + 1 <= heap_count && heap_keys[child] < heap_keys[child + 1])
            child = child + 1;
          if (!(heap_keys[idx] < heap_keys[child]))
            break;
          tmp = heap_keys[idx];
          heap_keys[idx] = heap_keys[child];
          heap_keys[child] = tmp;
          idx = child;
        end
        remove_count++;
      end
    end
    if (heap_count > peak_count)
      peak_count = heap_count;
    r.top   = (heap_count > 0) ? heap_keys[1] : '0;
    r.count = 8'(heap_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", result_count, field, got,
             want);
    mismatch_count++;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: pick_key = 32'($signed($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: pick_key = 32'h7fff_ffff;
          1: pick_key = 32'h8000_0000;
          2: pick_key = 32'h0000_0000;
          default: pick_key = 32'hffff_ffff;
        endcase
      end
      default: pick_key = $urandom;
    endcase
  endfunction

  task automatic push_op(logic mode, logic [31:0] value);
    heap_op_t op;
    op.mode  = mode;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_tvalid_i || expected_results.size() != 0);
  endtask

  // driver: draws a gap before each beat, with occasional gapless bursts
  always @(posedge clk_i or negedge rst_ni) begin
    heap_op_t op;
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tuser_i  <= '0;
      s_tdata_i  <= '0;
      send_gap   = 0;
      send_burst = 0;
    end else begin
      if (s_tvalid_i && s_tready_o)
        expected_results.push_back(heap_apply(s_tuser_i[0], s_tdata_i));
      if (!s_tvalid_i || s_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid_i <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          s_tvalid_i <= 1'b1;
          s_tuser_i  <= op.mode;
          s_tdata_i  <= op.value;
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else begin
            send_gap = $urandom_range(0, 3);
            if ($urandom_range(0, 15) == 0)
              send_burst = $urandom_range(10, 30);
          end
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat and stalls ready between beats
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      recv_stall = 0;
      recv_burst = 0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata_o[31:0], 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata_o[31:0] !== want.removed)
            report_mismatch("removed_value", m_tdata_o[31:0], want.removed);
          if (m_tdata_o[63:32] !== want.top)
            report_mismatch("top_value", m_tdata_o[63:32], want.top);
          if (m_tdata_o[71:64] !== want.count)
            report_mismatch("entry_count", 32'(m_tdata_o[71:64]), 32'(want.count));
          if (m_tdata_o[73:72] !== want.status)
            report_mismatch("status", 32'(m_tdata_o[73:72]), 32'(want.status));
        end
        result_count++;
        if (recv_burst > 0) begin
          recv_burst--;
          recv_stall = 0;
        end else begin
          recv_stall = $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0)
            recv_burst = $urandom_range(10, 30);
        end
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_tready_i <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int remove_pct;
    heap_count     = 0;
    mismatch_count = 0;
    result_count   = 0;
    insert_count   = 0;
    remove_count   = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    peak_count     = 0;
    cycle_count    = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty removal, extreme keys, equal keys, drain past empty
    push_op(MODE_REMOVE, 32'hdead_beef);
    push_op(MODE_INSERT, 32'h0000_0000);
    push_op(MODE_INSERT, 32'h7fff_ffff);
    push_op(MODE_INSERT, 32'h8000_0000);
    push_op(MODE_INSERT, 32'hffff_ffff);
    push_op(MODE_INSERT, 32'h0000_0001);
    push_op(MODE_INSERT, 32'h7fff_ffff);
    push_op(MODE_INSERT, 32'h8000_0000);
    repeat (8) push_op(MODE_REMOVE, $urandom);
    push_op(MODE_INSERT, 32'd5);
    push_op(MODE_INSERT, 32'd5);
    push_op(MODE_INSERT, 32'd5);
    repeat (3) push_op(MODE_REMOVE, 32'hffff_ffff);
    wait_drained();

    // fill to capacity, bounce off the full limit, then drain past empty
    repeat (mhpq_pkg::CAPACITY) push_op(MODE_INSERT, pick_key());
    repeat (3) push_op(MODE_INSERT, pick_key());
    push_op(MODE_REMOVE, $urandom);
    push_op(MODE_INSERT, pick_key());
    push_op(MODE_INSERT, pick_key());
    repeat (mhpq_pkg::CAPACITY + 2) push_op(MODE_REMOVE, $urandom);
    wait_drained();

    // random mix in segments that lean toward growth, balance or shrink
    repeat (10) begin
      case ($urandom_range(0, 2))
        0: remove_pct = 25;
        1: remove_pct = 50;
        default: remove_pct = 70;
      endcase
      repeat (33) begin
        if ($urandom_range(0, 99) < remove_pct)
          push_op(MODE_REMOVE, $urandom);
        else
          push_op(MODE_INSERT, pick_key());
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts, %0d removals, %0d full and %0d empty refusals",
             insert_count, remove_count, full_refusals, empty_refusals);
    $display("heap reached %0d entries, %0d result beats checked", peak_count, result_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_ctrl.sv
sv/mhpq_dp.sv
sv/max_heap_priority_queue.sv
bench/testbench.sv
